// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int NWRD_W     = WIDX_W + 1;
  localparam int SCAN_LANES = 8;
  localparam int LANE_W     = $clog2(SCAN_LANES);
  localparam int CHUNK_W    = WIDX_W - LANE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_BLOCKS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [0:0] {
    REG_TOTAL_BLOCKS = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_BLOCKS    = 2'd1,
    ST_DOUBLE_FREE  = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic fail;
    logic commit_alloc;
    logic commit_free;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: accept, chunked free-word scan, check and commit.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACHK = 4'b0100,
    S_FCHK = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.req_free ? S_FCHK : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = S_ACHK;
        end else if (sts.scan_last && sts.out_free) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ACHK: begin
        if (sts.out_free) begin
          cmd.commit_alloc = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_FCHK: begin
        if (sts.out_free) begin
          cmd.commit_free = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Bitmap word memory with per-word valid and full flags, scan, update logic
// and the result register.
// ----------------------------------------------------------------------------
module bba_dp
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [CNT_W-1:0]  cnt,
  input  logic              in_operation,
  input  logic [BLK_W-1:0]  in_block_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BLK_W-1:0]  out_allocated_block,
  output logic [1:0]        out_status
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [NUM_WORDS-1:0] full_r;

  logic [BLK_W-1:0]   blk_r;
  logic [WIDX_W-1:0]  word_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [WORD_W-1:0]  q_r;
  logic               q_vld_r;

  logic               out_valid_r;
  logic [BLK_W-1:0]   out_alloc_r;
  status_t            out_status_r;

  logic [NWRD_W-1:0]  nwords;
  logic [NWRD_W-1:0]  cnt_word;
  logic [NWRD_W-1:0]  next_base;
  logic [WIDX_W-1:0]  lane_idx [SCAN_LANES];
  logic [SCAN_LANES-1:0] cand;
  logic [LANE_W-1:0]  hit_lane;
  logic [WIDX_W-1:0]  hit_word;
  logic [WIDX_W-1:0]  rd_addr;
  logic               rd_en;

  logic [WORD_W-1:0]  data;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  avail;
  logic [BIT_W-1:0]   fbit;
  logic               found;
  logic [WORD_W-1:0]  alloc_word;
  logic [BIT_W-1:0]   fsel;
  logic               in_range;
  logic               bit_used;
  logic [WORD_W-1:0]  free_word;

  logic               we;
  logic [WORD_W-1:0]  wdata;
  logic               push;
  logic [BLK_W-1:0]   res_alloc;
  status_t            res_status;

  // scan: eight full flags per cycle, limited to words below the count
  always_comb begin
    nwords    = NWRD_W'((cnt + CNT_W'(WORD_W - 1)) >> BIT_W);
    next_base = {1'b0, chunk_r, {LANE_W{1'b0}}} + NWRD_W'(SCAN_LANES);
    for (int k = 0; k < SCAN_LANES; k++) begin
      lane_idx[k] = {chunk_r, LANE_W'(k)};
      cand[k]     = !full_r[lane_idx[k]] && ({1'b0, lane_idx[k]} < nwords);
    end
    hit_lane = '0;
    for (int k = SCAN_LANES - 1; k >= 0; k--) begin
      if (cand[k]) hit_lane = LANE_W'(k);
    end
    hit_word = {chunk_r, hit_lane};
  end

  assign sts.req_free  = (in_operation == OP_FREE);
  assign sts.scan_hit  = |cand;
  assign sts.scan_last = (next_base >= nwords);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign rd_en   = cmd.accept || (cmd.scan && sts.scan_hit);
  assign rd_addr = cmd.accept ? in_block_number[BLK_W-1:BIT_W] : hit_word;

  // word check for allocate and free
  always_comb begin
    data     = q_vld_r ? q_r : '0;
    cnt_word = NWRD_W'(cnt >> BIT_W);
    for (int b = 0; b < WORD_W; b++) begin
      mask[b] = ({1'b0, word_r} == cnt_word) && (BIT_W'(b) >= cnt[BIT_W-1:0]);
    end
    avail = ~(data | mask);
    found = |avail;
    fbit  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) fbit = BIT_W'(b);
    end
    alloc_word = data | (WORD_W'(1) << fbit);
    fsel       = blk_r[BIT_W-1:0];
    in_range   = ({1'b0, blk_r} < cnt);
    bit_used   = data[fsel];
    free_word  = data & ~(WORD_W'(1) << fsel);
  end

  always_comb begin
    we         = 1'b0;
    wdata      = alloc_word;
    res_alloc  = '0;
    res_status = ST_NO_BLOCKS;
    if (cmd.commit_alloc) begin
      if (found) begin
        we         = 1'b1;
        res_alloc  = {word_r, fbit};
        res_status = ST_OK;
      end
    end else if (cmd.commit_free) begin
      wdata = free_word;
      if (!in_range) begin
        res_status = ST_OUT_OF_RANGE;
      end else if (!bit_used) begin
        res_status = ST_DOUBLE_FREE;
      end else begin
        we         = 1'b1;
        res_status = ST_OK;
      end
    end
  end

  assign push = cmd.fail || cmd.commit_alloc || cmd.commit_free;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[word_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_vld_r <= vld_r[rd_addr];
      word_r  <= rd_addr;
    end
    if (cmd.accept) begin
      blk_r <= in_block_number;
    end
    if (push) begin
      out_alloc_r  <= res_alloc;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      full_r      <= '0;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[word_r]  <= 1'b1;
        full_r[word_r] <= &wdata;
      end
      if (cmd.accept) begin
        chunk_r <= '0;
      end else if (cmd.scan && !sts.scan_hit && !sts.scan_last) begin
        chunk_r <= chunk_r + CHUNK_W'(1);
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_alloc_r;
  assign out_status          = out_status_r;

endmodule

// ===== hdl/block_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit bitmap block allocator: one used bit per block, 4096 blocks.
//
// Input channel (in_valid/in_ready): in_operation selects allocate or free,
// in_block_number names the block to free. One item is in flight at a time.
// Result channel (out_valid/out_ready): allocated block number and status.
// Steps from accept to a result: a free reads the named word, then checks and
// writes it; an allocate runs the free-word scan, which checks the full flags of
// eight 32-bit bitmap words per cycle over the 128 words, reads the word it hits,
// and then checks and writes that word. When the result is loaded, the sequencer
// returns to idle, ready for the next item.
// The result register parts the channels: a new item is accepted while a
// result still waits; the block stalls in its final cycle only while the
// receiver holds a previous result.
// Reset clears the per-word valid and full flags at once, so the whole
// bitmap reads as free from the first cycle; no clearing pass is needed.
// total_blocks (APB, byte address 0) resets to 4096; write it only when idle.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [BLK_W-1:0]      in_block_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BLK_W-1:0]      out_allocated_block,
  output logic [1:0]            out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] cnt;
  logic             sel_total;
  cmd_t             cmd;
  sts_t             sts;

  assign pready    = 1'b1;
  assign sel_total = (paddr[CFG_ADDR_W-1:2] == REG_TOTAL_BLOCKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (psel && penable && pwrite && sel_total) begin
      total_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = sel_total ? CFG_DATA_W'(total_r) : '0;

  // clamp the count to the bitmap size
  assign cnt = (total_r > TOTAL_RESET) ? TOTAL_RESET : total_r;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cnt                 (cnt),
    .in_operation        (in_operation),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status)
  );

endmodule

// ===== bench/block_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit_tb
// Self-checking bench for the first-fit bitmap block allocator. A local
// mirror of the used-block map predicts the block number and status of every
// allocate and free request. Each result is compared with the oldest
// prediction. The run covers directed corner cases, mixed traffic under
// several block counts and idle patterns, and a fill of the map under a
// reduced block count.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit_tb
  import bba_pkg::*;
();

  localparam int DRAIN_CYCLES = 24;
  localparam int FILL_BLOCKS  = 400;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TOTAL    = CFG_ADDR_W'(4 * int'(REG_TOTAL_BLOCKS));
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED =
    CFG_ADDR_W'(4 * (int'(REG_TOTAL_BLOCKS) + 1));

  typedef struct {
    logic [BLK_W-1:0] blk;
    status_t          status;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_ALLOC;
  logic [BLK_W-1:0]      in_block_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BLK_W-1:0]      out_allocated_block;
  logic [1:0]            out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [MAX_BLOCKS-1:0] used_map = '0;
  logic [CNT_W-1:0]      blocks_cfg = TOTAL_RESET;
  logic [BLK_W-1:0]      live_blocks[$];
  alloc_result_t         pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int highest_block = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  block_bitmap_allocator_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  function automatic int effective_count();
    return (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
  endfunction

  function automatic int free_blocks_left();
    int n;
    int limit;
    n = 0;
    limit = effective_count();
    for (int i = 0; i < limit; i++) begin
      if (!used_map[i]) n++;
    end
    return n;
  endfunction

  function automatic alloc_result_t predict_request(logic op, logic [BLK_W-1:0] blk);
    alloc_result_t r;
    int limit;
    limit = effective_count();
    r.blk = '0;
    r.status = ST_NO_BLOCKS;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < limit; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          r.blk = BLK_W'(i);
          r.status = ST_OK;
          live_blocks.push_back(r.blk);
          if (i > highest_block) highest_block = i;
          break;
        end
      end
    end else if (int'(blk) >= limit) begin
      r.status = ST_OUT_OF_RANGE;
    end else if (!used_map[blk]) begin
      r.status = ST_DOUBLE_FREE;
    end else begin
      used_map[blk] = 1'b0;
      r.status = ST_OK;
      for (int j = 0; j < live_blocks.size(); j++) begin
        if (live_blocks[j] == blk) begin
          live_blocks.delete(j);
          break;
        end
      end
    end
    status_tally[r.status]++;
    return r;
  endfunction

  // Call right after a rising edge; returns right after the accepting edge.
  task automatic issue_request(input logic op, input logic [BLK_W-1:0] blk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_block_number <= blk;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_request(op, blk));
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] readback;
    wait_idle();
    apb_access(1'b1, addr, data, readback);
    if (addr == ADDR_TOTAL) blocks_cfg = data[CNT_W-1:0];
    cfg_writes++;
    apb_access(1'b0, ADDR_TOTAL, '0, readback);
    if (readback !== CFG_DATA_W'(blocks_cfg))
      flag_error("total_blocks readback", CFG_DATA_W'(blocks_cfg), readback);
  endtask

  task automatic run_mixed_traffic(input int setting, input int n_items, input int alloc_pct);
    int limit;
    int roll;
    write_register(ADDR_TOTAL, CFG_DATA_W'(setting));
    for (int k = 0; k < n_items; k++) begin
      limit = effective_count();
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        issue_request(OP_ALLOC, BLK_W'($urandom));
      end else if (roll < 88 && live_blocks.size() > 0) begin
        issue_request(OP_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
      end else if (roll < 94) begin
        issue_request(OP_FREE, BLK_W'($urandom));
      end else begin
        issue_request(OP_FREE, BLK_W'(limit + $urandom_range(3)));
      end
    end
    wait_idle();
  endtask

  task automatic test_directed_cases();
    write_register(ADDR_UNMAPPED, 32'd3);
    issue_request(OP_ALLOC, '1);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_ALLOC, 12'h555);
    issue_request(OP_FREE, 12'd1);
    issue_request(OP_FREE, 12'd1);
    issue_request(OP_ALLOC, 12'haaa);
    issue_request(OP_FREE, '1);
    issue_request(OP_FREE, '0);
    write_register(ADDR_TOTAL, 32'd1);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_FREE, 12'd1);
    issue_request(OP_FREE, '1);
    write_register(ADDR_TOTAL, 32'd0);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_FREE, '0);
    write_register(ADDR_TOTAL, 32'd8191);
    issue_request(OP_FREE, '1);
    issue_request(OP_ALLOC, '0);
    write_register(ADDR_TOTAL, 32'd8);
    repeat (5) issue_request(OP_ALLOC, '0);
    // shrink below used blocks, then raise again
    write_register(ADDR_TOTAL, 32'd4);
    issue_request(OP_FREE, 12'd6);
    issue_request(OP_ALLOC, '0);
    write_register(ADDR_TOTAL, 32'd8);
    issue_request(OP_FREE, 12'd6);
    issue_request(OP_ALLOC, '0);
    wait_idle();
  endtask

  task automatic test_tight_counts();
    run_mixed_traffic(16, 160, 55);
    run_mixed_traffic(1, 50, 50);
  endtask

  task automatic test_word_boundaries();
    run_mixed_traffic(300, 180, 60);
    run_mixed_traffic(33, 150, 55);
    run_mixed_traffic(0, 30, 50);
  endtask

  task automatic test_large_counts();
    run_mixed_traffic(8191, 160, 60);
    run_mixed_traffic(64, 120, 50);
  endtask

  task automatic test_full_map();
    write_register(ADDR_TOTAL, CFG_DATA_W'(FILL_BLOCKS));
    while (free_blocks_left() > 0) begin
      if (live_blocks.size() > 0 && $urandom_range(15) == 0)
        issue_request(OP_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
      else
        issue_request(OP_ALLOC, BLK_W'($urandom));
    end
    repeat (3) issue_request(OP_ALLOC, BLK_W'($urandom));
    repeat (8) issue_request(OP_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
    repeat (9) issue_request(OP_ALLOC, BLK_W'($urandom));
    wait_idle();
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result with nothing pending", '0, 32'(out_allocated_block));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_allocated_block !== want.blk)
          flag_error("allocated_block", 32'(want.blk), 32'(out_allocated_block));
        if (out_status !== want.status)
          flag_error("status", 32'(want.status), 32'(out_status));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 16;
    recv_stall_pct = 47;
    test_directed_cases();
    test_tight_counts();

    send_idle_pct = 47;
    recv_stall_pct = 16;
    test_word_boundaries();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_large_counts();
    test_full_map();

    if (pending_results.size() != 0)
      flag_error("results never delivered", '0, 32'(pending_results.size()));
    $display("Sent %0d requests over %0d register writes; %0d results checked.",
             requests_sent, cfg_writes, results_checked);
    $display("Ok %0d, out of blocks %0d, double free %0d, out of range %0d; top block %0d.",
             status_tally[ST_OK], status_tally[ST_NO_BLOCKS], status_tally[ST_DOUBLE_FREE],
             status_tally[ST_OUT_OF_RANGE], highest_block);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
